>>> rtl/core/psr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psr_pkg
// Shared types and constants for the polyline segment resampler.
// ----------------------------------------------------------------------------
package psr_pkg;

    localparam int unsigned COORD_W   = 32;
    localparam int unsigned LEN_W     = 31;
    localparam int unsigned MAG_W     = 33;          // |coordinate difference|
    localparam int unsigned SQ_W      = 2 * MAG_W;   // dx^2 + dy^2
    localparam int unsigned ROOT_W    = 33;          // floor sqrt of SQ_W bits
    localparam int unsigned STEP_CNT_W = 6;          // counts 33 iterations
    localparam logic [STEP_CNT_W-1:0] SQRT_LAST = 6'd32;
    localparam logic [STEP_CNT_W-1:0] DIV_LAST  = 6'd32;
    localparam logic [LEN_W-1:0] LEN_RESET = 31'd65536;

    // Input commands
    localparam logic CMD_SEED   = 1'b0;
    localparam logic CMD_VERTEX = 1'b1;

    // Input item
    typedef struct packed {
        logic                      command;
        logic signed [COORD_W-1:0] in_x;
        logic signed [COORD_W-1:0] in_y;
    } t_in;

    // Result item
    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      run_last;
    } t_out;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_M,
        ST_TEST,
        ST_SQRT,
        ST_SEARCH,
        ST_DIV,
        ST_EMIT
    } t_state;

endpackage

>>> rtl/core/psr_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psr_sqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module psr_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [psr_pkg::SQ_W-1:0]        i_radicand,
    output logic                            o_done,
    output logic [psr_pkg::ROOT_W-1:0]      o_root,
    output logic                            o_exact
);
    logic [psr_pkg::SQ_W-1:0]           r_x;
    logic [psr_pkg::ROOT_W:0]           r_rem;
    logic [psr_pkg::ROOT_W-1:0]         r_root;
    logic [psr_pkg::STEP_CNT_W-1:0]     r_cnt;
    logic                               r_busy;
    logic                               r_done;
    logic [psr_pkg::ROOT_W+2:0]         w_shift;
    logic [psr_pkg::ROOT_W+2:0]         w_trial;
    logic                               w_fit;

    // One root bit per step
    assign w_shift = {r_rem, r_x[psr_pkg::SQ_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_fit   = (w_shift >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == psr_pkg::SQRT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x <= {r_x[psr_pkg::SQ_W-3:0], 2'b00};
            if (w_fit) begin
                r_rem  <= (psr_pkg::ROOT_W+1)'(w_shift - w_trial);
                r_root <= {r_root[psr_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_shift[psr_pkg::ROOT_W:0];
                r_root <= {r_root[psr_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done  = r_done;
    assign o_root  = r_root;
    assign o_exact = (r_rem == '0);

endmodule

>>> rtl/core/psr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psr_div
// Two-lane restoring divider: both magnitudes by the same small step count.
// ----------------------------------------------------------------------------
module psr_div #(
    parameter int unsigned NW = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [psr_pkg::MAG_W-1:0]     i_num_x,
    input  logic [psr_pkg::MAG_W-1:0]     i_num_y,
    input  logic [NW-1:0]                 i_den,
    output logic                          o_done,
    output logic [psr_pkg::MAG_W-1:0]     o_quo_x,
    output logic [psr_pkg::MAG_W-1:0]     o_quo_y,
    output logic [NW-1:0]                 o_rem_x,
    output logic [NW-1:0]                 o_rem_y
);
    logic [psr_pkg::MAG_W-1:0]        r_ax, r_ay;
    logic [NW-1:0]                    r_rx, r_ry, r_den;
    logic [psr_pkg::STEP_CNT_W-1:0]   r_cnt;
    logic                             r_busy;
    logic                             r_done;
    logic [NW:0]                      w_tx, w_ty;
    logic                             w_fx, w_fy;

    // Shift in one dividend bit per lane and test
    assign w_tx = {r_rx, r_ax[psr_pkg::MAG_W-1]};
    assign w_ty = {r_ry, r_ay[psr_pkg::MAG_W-1]};
    assign w_fx = (w_tx >= {1'b0, r_den});
    assign w_fy = (w_ty >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == psr_pkg::DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ax  <= i_num_x;
            r_ay  <= i_num_y;
            r_rx  <= '0;
            r_ry  <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_ax <= {r_ax[psr_pkg::MAG_W-2:0], w_fx};
            r_ay <= {r_ay[psr_pkg::MAG_W-2:0], w_fy};
            r_rx <= w_fx ? NW'(w_tx - {1'b0, r_den}) : w_tx[NW-1:0];
            r_ry <= w_fy ? NW'(w_ty - {1'b0, r_den}) : w_ty[NW-1:0];
        end
    end

    assign o_done  = r_done;
    assign o_quo_x = r_ax;
    assign o_quo_y = r_ay;
    assign o_rem_x = r_rx;
    assign o_rem_y = r_ry;

endmodule

>>> rtl/core/polyline_segment_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_segment_resampler
// Splits each incoming polyline edge into evenly spaced output points.
// ----------------------------------------------------------------------------
// One vertex is taken at a time. After a vertex is accepted, the one shared
// 33x33 multiplier forms the squared length and m*m (three products), then
// comes the drop test; a dropped vertex ends there. Then follow the square
// root (two radicand bits per cycle), the search for the point count n (one
// add of 2*m per try), the per-axis division by n, and the emitted points,
// one per cycle when the output is not stalled. The last point is held in
// the output register, so the next vertex is accepted while it waits.
module polyline_segment_resampler #(
    parameter int unsigned MAX_STEPS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  psr_pkg::t_in            i_in,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output psr_pkg::t_out           o_out,
    input  logic                    i_cfg_we,
    input  logic [psr_pkg::LEN_W-1:0] i_cfg_data
);
    localparam int unsigned NW = $clog2(MAX_STEPS + 1);
    localparam int unsigned RW = psr_pkg::LEN_W + 1 + NW;
    localparam int unsigned CW = (RW > psr_pkg::ROOT_W + 1) ? RW : psr_pkg::ROOT_W + 1;
    localparam int unsigned MW = psr_pkg::MAG_W;

    psr_pkg::t_state r_state, n_state;

    logic [psr_pkg::LEN_W-1:0]     r_len;
    logic [psr_pkg::COORD_W-1:0]   r_px, r_py, r_vx, r_vy;
    logic [MW-1:0]                 r_mx, r_my;
    logic                          r_sx, r_sy;
    logic [psr_pkg::SQ_W-1:0]      r_sq;
    logic [2*psr_pkg::LEN_W-1:0]   r_mm;
    logic [psr_pkg::ROOT_W:0]      r_root;
    logic [RW-1:0]                 r_reach;
    logic [NW-1:0]                 r_n, r_k;
    logic [MW-1:0]                 r_qdx, r_qdy, r_qx, r_qy;
    logic [NW-1:0]                 r_rdx, r_rdy, r_rx, r_ry;
    logic                          r_out_valid;
    psr_pkg::t_out                 r_out;

    logic                          w_accept;
    logic [MW-1:0]                 w_ma, w_mb;
    logic [psr_pkg::SQ_W-1:0]      w_prod;
    logic [psr_pkg::SQ_W+6:0]      w_sq100;
    logic                          w_drop;
    logic                          w_found;
    logic                          w_load;
    logic                          w_last;
    logic                          w_sqrt_start, w_sqrt_done, w_sqrt_exact;
    logic [psr_pkg::ROOT_W-1:0]    w_sqrt_root;
    logic                          w_div_start, w_div_done;
    logic [MW-1:0]                 w_quo_x, w_quo_y;
    logic [NW-1:0]                 w_rem_x, w_rem_y;
    logic [MW-1:0]                 w_nqx, w_nqy;
    logic [NW:0]                   w_tx, w_ty;
    logic [MW-1:0]                 w_px_ext, w_py_ext, w_ox, w_oy;
    logic signed [MW-1:0]          w_dx, w_dy;

    assign w_accept = i_in_valid && o_in_ready;

    // Coordinate differences against the previous point
    assign w_dx = $signed({i_in.in_x[psr_pkg::COORD_W-1], i_in.in_x})
                - $signed({r_px[psr_pkg::COORD_W-1], r_px});
    assign w_dy = $signed({i_in.in_y[psr_pkg::COORD_W-1], i_in.in_y})
                - $signed({r_py[psr_pkg::COORD_W-1], r_py});

    // Shared multiplier
    always_comb begin
        case (r_state)
            psr_pkg::ST_MUL_X: begin
                w_ma = r_mx;
                w_mb = r_mx;
            end
            psr_pkg::ST_MUL_Y: begin
                w_ma = r_my;
                w_mb = r_my;
            end
            default: begin
                w_ma = {2'b00, r_len};
                w_mb = {2'b00, r_len};
            end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // Drop test: 100*S < m*m
    assign w_sq100 = {r_sq, 6'd0} + {1'b0, r_sq, 5'd0} + {4'd0, r_sq, 2'd0};
    assign w_drop  = (w_sq100 < (psr_pkg::SQ_W+7)'(r_mm));

    // Point count search
    assign w_found = (CW'(r_reach) >= CW'(r_root)) || (r_n == NW'(MAX_STEPS));

    // Point emission
    assign w_load = (r_state == psr_pkg::ST_EMIT) && (!r_out_valid || i_out_ready);
    assign w_last = (r_k == NW'(r_n - 1'b1));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psr_pkg::ST_IDLE: begin
                if (w_accept && (i_in.command == psr_pkg::CMD_VERTEX)) begin
                    n_state = psr_pkg::ST_MUL_X;
                end
            end
            psr_pkg::ST_MUL_X:  n_state = psr_pkg::ST_MUL_Y;
            psr_pkg::ST_MUL_Y:  n_state = psr_pkg::ST_MUL_M;
            psr_pkg::ST_MUL_M:  n_state = psr_pkg::ST_TEST;
            psr_pkg::ST_TEST:   n_state = w_drop ? psr_pkg::ST_IDLE : psr_pkg::ST_SQRT;
            psr_pkg::ST_SQRT: begin
                if (w_sqrt_done) n_state = psr_pkg::ST_SEARCH;
            end
            psr_pkg::ST_SEARCH: begin
                if (w_found) n_state = psr_pkg::ST_DIV;
            end
            psr_pkg::ST_DIV: begin
                if (w_div_done) n_state = psr_pkg::ST_EMIT;
            end
            psr_pkg::ST_EMIT: begin
                if (w_load && w_last) n_state = psr_pkg::ST_IDLE;
            end
            default:            n_state = psr_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_ready   = 1'b0;
        w_sqrt_start = 1'b0;
        w_div_start  = 1'b0;
        unique case (r_state)
            psr_pkg::ST_IDLE:   o_in_ready   = 1'b1;
            psr_pkg::ST_TEST:   w_sqrt_start = !w_drop;
            psr_pkg::ST_SEARCH: w_div_start  = w_found;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= psr_pkg::LEN_RESET;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_data;
        end
    end

    // Previous point: loaded by a seed, or when the last point enters the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_py <= '0;
        end else if (w_accept && (i_in.command == psr_pkg::CMD_SEED)) begin
            r_px <= i_in.in_x;
            r_py <= i_in.in_y;
        end else if (w_load && w_last) begin
            r_px <= r_vx;
            r_py <= r_vy;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_vx <= i_in.in_x;
            r_vy <= i_in.in_y;
            r_sx <= w_dx[MW-1];
            r_sy <= w_dy[MW-1];
            r_mx <= w_dx[MW-1] ? MW'(-w_dx) : MW'(w_dx);
            r_my <= w_dy[MW-1] ? MW'(-w_dy) : MW'(w_dy);
        end
        case (r_state)
            psr_pkg::ST_MUL_X: r_sq <= w_prod;
            psr_pkg::ST_MUL_Y: r_sq <= r_sq + w_prod;
            psr_pkg::ST_MUL_M: r_mm <= w_prod[2*psr_pkg::LEN_W-1:0];
            default: ;
        endcase
        if (w_sqrt_start) begin
            r_n     <= NW'(1);
            r_reach <= RW'({r_len, 1'b0});
        end
        if (w_sqrt_done) begin
            r_root <= {1'b0, w_sqrt_root} + {{psr_pkg::ROOT_W{1'b0}}, !w_sqrt_exact};
        end
        if (r_state == psr_pkg::ST_SEARCH && !w_found) begin
            r_n     <= r_n + 1'b1;
            r_reach <= r_reach + RW'({r_len, 1'b0});
        end
        if (w_div_done) begin
            r_qdx <= w_quo_x;
            r_qdy <= w_quo_y;
            r_rdx <= w_rem_x;
            r_rdy <= w_rem_y;
            r_qx  <= '0;
            r_qy  <= '0;
            r_rx  <= r_n >> 1;
            r_ry  <= r_n >> 1;
            r_k   <= '0;
        end
        if (w_load) begin
            r_qx <= w_nqx;
            r_qy <= w_nqy;
            r_rx <= (w_tx >= {1'b0, r_n}) ? NW'(w_tx - {1'b0, r_n}) : w_tx[NW-1:0];
            r_ry <= (w_ty >= {1'b0, r_n}) ? NW'(w_ty - {1'b0, r_n}) : w_ty[NW-1:0];
            r_k  <= r_k + 1'b1;
            r_out.out_x    <= w_ox[psr_pkg::COORD_W-1:0];
            r_out.out_y    <= w_oy[psr_pkg::COORD_W-1:0];
            r_out.run_last <= w_last;
        end
    end

    // Running quotient of |d|*(k+1) + n/2 over n, one step per point
    assign w_tx  = {1'b0, r_rx} + {1'b0, r_rdx};
    assign w_ty  = {1'b0, r_ry} + {1'b0, r_rdy};
    assign w_nqx = r_qx + r_qdx + MW'(w_tx >= {1'b0, r_n});
    assign w_nqy = r_qy + r_qdy + MW'(w_ty >= {1'b0, r_n});

    assign w_px_ext = {r_px[psr_pkg::COORD_W-1], r_px};
    assign w_py_ext = {r_py[psr_pkg::COORD_W-1], r_py};
    assign w_ox     = r_sx ? (w_px_ext - w_nqx) : (w_px_ext + w_nqx);
    assign w_oy     = r_sy ? (w_py_ext - w_nqy) : (w_py_ext + w_nqy);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    psr_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (r_sq),
        .o_done     (w_sqrt_done),
        .o_root     (w_sqrt_root),
        .o_exact    (w_sqrt_exact)
    );

    psr_div #(
        .NW (NW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num_x (r_mx),
        .i_num_y (r_my),
        .i_den   (r_n),
        .o_done  (w_div_done),
        .o_quo_x (w_quo_x),
        .o_quo_y (w_quo_y),
        .o_rem_x (w_rem_x),
        .o_rem_y (w_rem_y)
    );

`ifndef ASSERT_OFF
    // Point index stays below the point count while emitting
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psr_pkg::ST_EMIT) |-> (r_k < r_n))
        else $error("point index past point count");

    // Point count is within 1..MAX_STEPS once chosen
    a_n_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psr_pkg::ST_EMIT) |-> (r_n >= NW'(1) && r_n <= NW'(MAX_STEPS)))
        else $error("point count out of range");

    // Root unit finishes only while the sequencer waits for it
    a_sqrt_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sqrt_done |-> (r_state == psr_pkg::ST_SQRT))
        else $error("unexpected square root completion");

    // Divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == psr_pkg::ST_DIV))
        else $error("unexpected divider completion");
`endif

endmodule

>>> test/tb_polyline_segment_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyline_segment_resampler
// Self-checking testbench for the polyline segment resampler.
// ----------------------------------------------------------------------------
// A directed table of seeds and vertices runs first. Random polylines follow,
// under several length settings and idle patterns on both channels. Every
// output point is compared with a scoreboard filled by a behavioral model of
// the resampling arithmetic.
// ----------------------------------------------------------------------------
module tb_polyline_segment_resampler;

    localparam int unsigned STEPS     = 64;
    localparam int unsigned WD_LIMIT  = 20000;
    localparam int unsigned DRAIN_CYC = 200;
    localparam logic        CMD_SEED  = psr_pkg::CMD_SEED;
    localparam logic        CMD_VERT  = psr_pkg::CMD_VERTEX;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    psr_pkg::t_in    i_in;
    logic            o_out_valid;
    logic            i_out_ready;
    psr_pkg::t_out   o_out;
    logic            i_cfg_we;
    logic [psr_pkg::LEN_W-1:0] i_cfg_data;

    polyline_segment_resampler #(.MAX_STEPS(STEPS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Model state and scoreboard
    psr_pkg::t_out      point_q[$];
    logic signed [31:0] prev_x, prev_y;
    logic [psr_pkg::LEN_W-1:0] seg_len;
    int                 errors;
    int                 sent, got;
    int                 pushed;
    int                 rx_idle_pct;
    int                 rx_hold;
    int                 wd_cnt;

    // Offset d*num/den, round to nearest, ties away from zero
    function automatic longint scaled_offset(longint d, longint num, longint den);
        longint q;
        q = ((d < 0 ? -d : d) * num + den / 2) / den;
        return d < 0 ? -q : q;
    endfunction

    // Predict the points one item causes and update the model state
    task automatic resample_item(psr_pkg::t_in item);
        longint      dx, dy, n;
        logic signed [127:0] wdx, wdy;
        logic [127:0] sq, lim, reach;
        psr_pkg::t_out pt;
        if (item.command == CMD_SEED) begin
            prev_x = item.in_x;
            prev_y = item.in_y;
            return;
        end
        dx = longint'(item.in_x) - longint'(prev_x);
        dy = longint'(item.in_y) - longint'(prev_y);
        wdx = dx;
        wdy = dy;
        sq = wdx * wdx + wdy * wdy;
        if (sq * 100 < 128'(seg_len) * 128'(seg_len)) return;
        for (n = 1; n < STEPS; n++) begin
            reach = 128'(seg_len) * 2 * n;
            lim = reach * reach;
            if (!(lim < sq)) break;
        end
        for (longint k = 0; k < n; k++) begin
            pt.out_x    = 32'(longint'(prev_x) + scaled_offset(dx, k + 1, n));
            pt.out_y    = 32'(longint'(prev_y) + scaled_offset(dy, k + 1, n));
            pt.run_last = (k + 1 == n);
            point_q = {point_q, pt};
            pushed++;
        end
        prev_x = item.in_x;
        prev_y = item.in_y;
    endtask

    // Output checker and receiver stall
    always @(posedge i_clk) begin
        psr_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got++;
            if (point_q.size() == 0) begin
                $error("point with no expectation: %h", o_out);
                errors++;
            end else begin
                want = point_q.pop_front();
                if (o_out.out_x !== want.out_x) begin
                    $error("out_x expected %0d actual %0d", want.out_x, o_out.out_x);
                    errors++;
                end
                if (o_out.out_y !== want.out_y) begin
                    $error("out_y expected %0d actual %0d", want.out_y, o_out.out_y);
                    errors++;
                end
                if (o_out.run_last !== want.run_last) begin
                    $error("run_last expected %0b actual %0b", want.run_last,
                           o_out.run_last);
                    errors++;
                end
            end
        end
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            wd_cnt <= 0;
        end else if (wd_cnt >= WD_LIMIT) begin
            $display("FAIL polyline_segment_resampler");
            $finish;
        end else begin
            wd_cnt <= wd_cnt + 1;
        end
    end

    // Offer one item and wait for its transfer; valid stays up afterwards
    task automatic send_item(psr_pkg::t_in item, int gap_pct);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in       <= item;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        resample_item(item);
        sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (point_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_len(logic [psr_pkg::LEN_W-1:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        seg_len = v;
    endtask

    function automatic psr_pkg::t_in make_item(logic c, logic [31:0] x, logic [31:0] y);
        psr_pkg::t_in t;
        t.command = c;
        t.in_x = x;
        t.in_y = y;
        return t;
    endfunction

    // Random polylines with mostly valid vertex runs
    task automatic random_phase(int items, int gap_pct);
        int   span;
        psr_pkg::t_in it;
        for (int i = 0; i < items; i++) begin
            span = (seg_len == 0) ? 65536 : int'(seg_len);
            case ($urandom_range(9))
                0: it = make_item(CMD_SEED, $urandom, $urandom);
                1: it = make_item(1'($urandom_range(1)), $urandom, $urandom);
                2: it = make_item(CMD_VERT, prev_x + $urandom_range(span / 10 + 1),
                                  prev_y);
                default: it = make_item(CMD_VERT,
                        prev_x + int'($urandom_range(span * 3)) - span,
                        prev_y + int'($urandom_range(span * 3)) - span);
            endcase
            send_item(it, gap_pct);
        end
    endtask

    // Directed stimulus: command, x, y; expected single point where obvious
    typedef struct {
        logic        cmd;
        logic [31:0] x, y;
        int          npts;
        psr_pkg::t_out pt;
    } t_row;

    t_row rows[] = '{
        '{CMD_VERT, 32'h0, 32'h0, 0, '{0, 0, 0}},
        '{CMD_VERT, 32'h100, 32'h0, 0, '{0, 0, 0}},
        '{CMD_VERT, 32'h10000, 32'h0, 1, '{32'h10000, 32'h0, 1'b1}},
        '{CMD_SEED, 32'h80000000, 32'h80000000, 0, '{0, 0, 0}},
        '{CMD_VERT, 32'h7FFFFFFF, 32'h7FFFFFFF, -1, '{0, 0, 0}},
        '{CMD_VERT, 32'h80000000, 32'h7FFFFFFF, -1, '{0, 0, 0}},
        '{CMD_SEED, 32'h0, 32'h0, 0, '{0, 0, 0}},
        '{CMD_VERT, 32'h30000, 32'hFFFD0000, -1, '{0, 0, 0}},
        '{CMD_VERT, 32'h30000, 32'hFFFD0001, 0, '{0, 0, 0}},
        '{CMD_VERT, 32'hFFFF0000, 32'h00018000, -1, '{0, 0, 0}},
        '{CMD_SEED, 32'h00050000, 32'h00050000, 0, '{0, 0, 0}},
        '{CMD_VERT, 32'h00051999, 32'h00050000, 0, '{0, 0, 0}},
        '{CMD_VERT, 32'h0005199A, 32'h00050000, 1, '{32'h0005199A, 32'h00050000, 1'b1}}
    };

    initial begin
        int base_cnt;
        errors = 0; sent = 0; got = 0; pushed = 0; rx_idle_pct = 0; rx_hold = 0;
        wd_cnt = 0;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in = '0;
        i_out_ready = 1'b0; i_cfg_we = 1'b0; i_cfg_data = psr_pkg::LEN_RESET;
        prev_x = 0; prev_y = 0; seg_len = psr_pkg::LEN_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows; fixed expectations cross-checked against the model
        foreach (rows[r]) begin
            base_cnt = pushed;
            send_item(make_item(rows[r].cmd, rows[r].x, rows[r].y), 0);
            if (rows[r].npts >= 0 && pushed - base_cnt != rows[r].npts) begin
                $error("row %0d point count expected %0d actual %0d", r,
                       rows[r].npts, pushed - base_cnt);
                errors++;
            end
            if (rows[r].npts == 1 && point_q[$] !== rows[r].pt) begin
                $error("row %0d point expected %h actual %h", r, rows[r].pt, point_q[$]);
                errors++;
            end
        end

        // Zero length: nothing dropped, equal vertex one point, else the cap; then maximum length
        write_len('0);
        send_item(make_item(CMD_VERT, prev_x, prev_y), 0);
        send_item(make_item(CMD_VERT, prev_x + 1, prev_y), 0);
        write_len(31'h7FFFFFFF);
        send_item(make_item(CMD_SEED, 32'h80000000, 32'h0), 0);
        send_item(make_item(CMD_VERT, 32'h7FFFFFFF, 32'h0), 0);

        // Random phases across length settings and idle patterns
        write_len(psr_pkg::LEN_RESET);
        rx_idle_pct = 0;  random_phase(80, 0);
        rx_idle_pct = 0;  random_phase(80, 84);
        write_len(31'd4096);
        rx_idle_pct = 84; random_phase(80, 0);
        write_len(31'd1000000);
        rx_idle_pct = 34; random_phase(80, 34);

        // Long receiver hold-off while the sender keeps offering items
        write_len(31'd2000);
        rx_hold = 3000;
        rx_idle_pct = 0;  random_phase(60, 0);
        drain();
        write_len(31'd1);
        random_phase(20, 0);
        write_len(31'($urandom_range(31'h7FFFFFFF, 1)));
        random_phase(80, 20);

        drain();
        $display("Ran %0d input items giving %0d points over several length settings,",
                 sent, got);
        $display("with idle and stall phases on both channels.");
        if (errors == 0 && point_q.size() == 0) begin
            $display("PASS polyline_segment_resampler");
        end else begin
            $display("FAIL polyline_segment_resampler");
        end
        $finish;
    end
endmodule
